// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL of the framer.
// Both forms are clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hdgf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdgf_pkg
// Shared types and defaults for the half-duplex idle-gap framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hdgf_pkg;

	localparam int SEND_DEPTH_DEF    = 64;
	localparam int RECEIVE_DEPTH_DEF = 64;
	localparam logic [7:0] GAP_RESET = 8'd5;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_RX_BYTE = 3'd1,
		CMD_TX_DONE = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_START   = 3'd4,
		CMD_READ    = 3'd5,
		CMD_RELEASE = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_SENDING   = 3'd1,
		MODE_SENT      = 3'd2,
		MODE_RECEIVING = 3'd3,
		MODE_RECEIVED  = 3'd4
	} mode_t;

	// Per-beat result flags and scalar fields; store bytes join later.
	typedef struct packed {
		logic       accepted;
		logic       tx_valid;
		logic       rd_valid;
		logic       line_drive;
		logic [6:0] frame_length;
		mode_t      mode;
	} result_t;

endpackage

`default_nettype wire

// ===== design/hdgf_ram.sv =====
// ----------------------------------------------------------------------------
// hdgf_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module hdgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/hdgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdgf_ctrl
// Link mode machine: command decode, counters and store access requests.
// ----------------------------------------------------------------------------
`default_nettype none

module hdgf_ctrl #(
	parameter int SEND_DEPTH    = hdgf_pkg::SEND_DEPTH_DEF,
	parameter int RECEIVE_DEPTH = hdgf_pkg::RECEIVE_DEPTH_DEF,
	localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1,
	localparam int RAW = (RECEIVE_DEPTH > 1) ? $clog2(RECEIVE_DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [7:0]       cfg_wdata,
	input  wire logic             acc,
	input  wire logic [2:0]       cmd,
	input  wire logic [7:0]       data,
	input  wire logic [5:0]       index,
	input  wire logic [7:0]       length,
	output hdgf_pkg::result_t     res,
	output logic                  tx_we,
	output logic [SAW-1:0]        tx_waddr,
	output logic [7:0]            tx_wdata,
	output logic                  tx_re,
	output logic [SAW-1:0]        tx_raddr,
	output logic                  rx_we,
	output logic [RAW-1:0]        rx_waddr,
	output logic [7:0]            rx_wdata,
	output logic                  rx_re,
	output logic [RAW-1:0]        rx_raddr
);

	localparam int RPW = $clog2(RECEIVE_DEPTH + 1);
	localparam logic [8:0] SDEPTH9 = 9'(SEND_DEPTH);
	localparam logic [8:0] RDEPTH9 = 9'(RECEIVE_DEPTH);

	hdgf_pkg::mode_t mode_q, mode_d;
	logic [7:0]     gap_q;
	logic [7:0]     tx_pos_q, tx_pos_d;
	logic [7:0]     tx_total_q, tx_total_d;
	logic [RPW-1:0] rx_pos_q, rx_pos_d;
	logic [RPW-1:0] rx_total_q, rx_total_d;
	logic [7:0]     sil_q, sil_d;
	logic           drive_q, drive_d;

	logic [8:0] idx9;
	logic [8:0] rx_pos9_inc;
	logic [7:0] tx_pos_inc;
	logic [7:0] sil_inc;
	logic [7:0] len_sat;
	logic       accepted, tx_valid, rd_valid;

	assign idx9        = {3'b000, index};
	assign rx_pos9_inc = 9'(rx_pos_q) + 9'd1;
	assign tx_pos_inc  = (tx_pos_q == 8'hFF) ? tx_pos_q : tx_pos_q + 8'd1;
	assign sil_inc     = (sil_q == 8'hFF) ? sil_q : sil_q + 8'd1;
	assign len_sat     = ({1'b0, length} > SDEPTH9) ? SDEPTH9[7:0] : length;
	assign tx_wdata    = data;
	assign rx_wdata    = data;
	assign rx_waddr    = rx_pos9_inc[RAW-1:0] - RAW'(1);

	always_comb begin
		mode_d     = mode_q;
		tx_pos_d   = tx_pos_q;
		tx_total_d = tx_total_q;
		rx_pos_d   = rx_pos_q;
		rx_total_d = rx_total_q;
		sil_d      = sil_q;
		drive_d    = drive_q;
		accepted   = 1'b0;
		tx_valid   = 1'b0;
		rd_valid   = 1'b0;
		tx_we      = 1'b0;
		tx_waddr   = idx9[SAW-1:0];
		tx_re      = 1'b0;
		tx_raddr   = '0;
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		rx_raddr   = idx9[RAW-1:0];
		if (acc) begin
			unique case (hdgf_pkg::cmd_t'(cmd))
				hdgf_pkg::CMD_TICK: begin
					if (mode_q == hdgf_pkg::MODE_RECEIVING) begin
						sil_d = sil_inc;
						// gap of zero acts as one: sil_inc is never below one
						if (sil_inc >= gap_q) begin
							rx_total_d = rx_pos_q;
							rx_pos_d   = '0;
							mode_d     = hdgf_pkg::MODE_RECEIVED;
						end
					end
					if (mode_q == hdgf_pkg::MODE_SENT) begin
						drive_d = 1'b0;
						mode_d  = hdgf_pkg::MODE_IDLE;
					end
				end
				hdgf_pkg::CMD_RX_BYTE: begin
					rx_we = 1'b1;
					sil_d = '0;
					if (rx_pos9_inc >= RDEPTH9) begin
						rx_total_d = rx_pos9_inc[RPW-1:0];
						rx_pos_d   = '0;
						mode_d     = hdgf_pkg::MODE_RECEIVED;
					end else begin
						rx_pos_d = rx_pos9_inc[RPW-1:0];
						mode_d   = hdgf_pkg::MODE_RECEIVING;
					end
				end
				hdgf_pkg::CMD_TX_DONE: begin
					tx_pos_d = tx_pos_inc;
					if (tx_pos_inc < tx_total_q) begin
						tx_valid = 1'b1;
						tx_re    = 1'b1;
						tx_raddr = tx_pos_inc[SAW-1:0];
					end else begin
						mode_d = hdgf_pkg::MODE_SENT;
					end
				end
				hdgf_pkg::CMD_WRITE: begin
					tx_we = (idx9 < SDEPTH9);
				end
				hdgf_pkg::CMD_START: begin
					if (mode_q == hdgf_pkg::MODE_IDLE) begin
						accepted   = 1'b1;
						drive_d    = 1'b1;
						tx_total_d = len_sat;
						tx_pos_d   = '0;
						if (len_sat == 8'd0) begin
							mode_d = hdgf_pkg::MODE_SENT;
						end else begin
							mode_d   = hdgf_pkg::MODE_SENDING;
							tx_valid = 1'b1;
							tx_re    = 1'b1;
						end
					end
				end
				hdgf_pkg::CMD_READ: begin
					if (mode_q == hdgf_pkg::MODE_RECEIVED && idx9 < 9'(rx_total_q) &&
						idx9 < RDEPTH9) begin
						accepted = 1'b1;
						rd_valid = 1'b1;
						rx_re    = 1'b1;
					end
				end
				hdgf_pkg::CMD_RELEASE: begin
					if (mode_q == hdgf_pkg::MODE_RECEIVED) begin
						accepted = 1'b1;
						mode_d   = hdgf_pkg::MODE_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.accepted     = accepted;
		res.tx_valid     = tx_valid;
		res.rd_valid     = rd_valid;
		res.line_drive   = drive_d;
		res.frame_length = 7'(rx_total_d);
		res.mode         = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= hdgf_pkg::MODE_IDLE;
			gap_q      <= hdgf_pkg::GAP_RESET;
			tx_pos_q   <= '0;
			tx_total_q <= '0;
			rx_pos_q   <= '0;
			rx_total_q <= '0;
			sil_q      <= '0;
			drive_q    <= 1'b0;
		end else begin
			mode_q     <= mode_d;
			tx_pos_q   <= tx_pos_d;
			tx_total_q <= tx_total_d;
			rx_pos_q   <= rx_pos_d;
			rx_total_q <= rx_total_d;
			sil_q      <= sil_d;
			drive_q    <= drive_d;
			if (cfg_wen) begin
				gap_q <= cfg_wdata;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/half_duplex_idle_gap_framer.sv =====
// A result beat appears in the cycle after its command beat is taken.
// Throughput: one command beat per cycle unless m_tready stalls; store reads
// come from the RAM's registered port in the cycle the result register loads.
// Reset: arst_n clears the mode machine, counters, gap register (to 5) and
// the result valid; store contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// half_duplex_idle_gap_framer
// Half-duplex byte link framer with idle-gap frame closing and send store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module half_duplex_idle_gap_framer #(
	parameter int SEND_DEPTH    = hdgf_pkg::SEND_DEPTH_DEF,
	parameter int RECEIVE_DEPTH = hdgf_pkg::RECEIVE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [7:0]  cfg_wdata,   // frame_gap_ticks
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,     // data[7:0], index[13:8], length[21:14]
	input  wire logic [2:0]  s_tuser,     // cmd[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata      // accepted[0], tx_valid[1], tx_byte[9:2],
	                                      // line_drive[10], read_byte[18:11],
	                                      // frame_length[25:19], mode[28:26]
);

	localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
	localparam int RAW = (RECEIVE_DEPTH > 1) ? $clog2(RECEIVE_DEPTH) : 1;

	hdgf_pkg::result_t res, res_s1;
	logic           v_s1;
	logic           acc;
	logic           tx_we, tx_re, rx_we, rx_re;
	logic [SAW-1:0] tx_waddr, tx_raddr;
	logic [RAW-1:0] rx_waddr, rx_raddr;
	logic [7:0]     tx_wdata, rx_wdata, tx_rdata, rx_rdata;
	logic [7:0]     tx_byte, read_byte;

	// result register doubles as the output register; RAM read data holds
	// because a read is issued only on an accepted beat
	assign s_tready = !v_s1 || m_tready;
	assign acc      = s_tvalid && s_tready;

	hdgf_ctrl #(
		.SEND_DEPTH    (SEND_DEPTH),
		.RECEIVE_DEPTH (RECEIVE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.cmd       (s_tuser),
		.data      (s_tdata[7:0]),
		.index     (s_tdata[13:8]),
		.length    (s_tdata[21:14]),
		.res       (res),
		.tx_we     (tx_we),
		.tx_waddr  (tx_waddr),
		.tx_wdata  (tx_wdata),
		.tx_re     (tx_re),
		.tx_raddr  (tx_raddr),
		.rx_we     (rx_we),
		.rx_waddr  (rx_waddr),
		.rx_wdata  (rx_wdata),
		.rx_re     (rx_re),
		.rx_raddr  (rx_raddr)
	);

	hdgf_ram #(
		.WIDTH (8),
		.DEPTH (SEND_DEPTH)
	) u_send_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.re    (tx_re),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	hdgf_ram #(
		.WIDTH (8),
		.DEPTH (RECEIVE_DEPTH)
	) u_recv_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign tx_byte   = res_s1.tx_valid ? tx_rdata : 8'd0;
	assign read_byte = res_s1.rd_valid ? rx_rdata : 8'd0;
	assign m_tvalid  = v_s1;
	assign m_tdata   = {3'b000, res_s1.mode, res_s1.frame_length, read_byte,
		res_s1.line_drive, tx_byte, res_s1.tx_valid, res_s1.accepted};

	`ASSERT_IMPL(a_tx_needs_drive, clk, arst_n, v_s1 && res_s1.tx_valid, res_s1.line_drive, "tx byte without line drive")
	`ASSERT_IMPL(a_read_in_received, clk, arst_n, v_s1 && res_s1.rd_valid, res_s1.mode == hdgf_pkg::MODE_RECEIVED, "frame read outside received mode")
	`ASSERT_NEXT(a_stall_holds_result, clk, arst_n, v_s1 && !m_tready, v_s1 && $stable(m_tdata), "result changed while stalled")

endmodule

`default_nettype wire
